FILE: rtl/fatan_pkg.sv
// Shared types, constants and the breakpoint arctangent table for the
// single-precision arctangent pipeline. No dependencies.
`default_nettype none

package fatan_pkg;

  typedef struct packed {
    logic        sign;
    logic [7:0]  exp;
    logic [22:0] man;
  } fp_t;

  typedef enum logic [1:0] {
    PATH_SMALL,
    PATH_MID,
    PATH_RECIP
  } path_t;

  localparam logic [31:0] P1_BITS    = 32'hBEAAA5D5;  // -0.33329644
  localparam logic [31:0] ONE_BITS   = 32'h3F800000;
  localparam logic [31:0] PIO2_F     = 32'h3FC90FDB;
  localparam logic [63:0] PIO2_D     = 64'h3FF921FB54442D18;
  localparam logic [30:0] BIG_MAG    = 31'h5B000000;
  localparam logic [30:0] TINY_MAG   = 31'h31800000;
  localparam logic [30:0] INF_MAG    = 31'h7F800000;
  localparam logic [30:0] SIXTYFOUR  = 31'h42800000;
  localparam logic [30:0] SIXTY4TH   = 31'h3C800000;
  localparam logic [30:0] BRK_RND    = 31'h00040000;
  localparam logic [30:0] BRK_KEEP   = 31'h7FF80000;
  localparam logic [31:0] QUIET_BIT  = 32'h00400000;

  localparam int unsigned TAB_N = 193;
  typedef logic [63:0] tab_t [TAB_N];

  localparam real HALF_ATN_D = 0.46364760900080611621;
  localparam real PIO2_R     = 1.5707963267948966192;

  // Elaboration-time helpers: fill the breakpoint table.

  // Quotient of two positive normal doubles, rounded to nearest even, by
  // restoring long division on the mantissas.
  function automatic real div_pos(real n, real d);
    logic [63:0] nb;
    logic [63:0] db;
    logic [54:0] r;
    logic [54:0] dm;
    logic [53:0] q;
    logic [53:0] m;
    int          e;
    nb = $realtobits(n);
    db = $realtobits(d);
    r  = {2'b00, 1'b1, nb[51:0]};
    dm = {2'b00, 1'b1, db[51:0]};
    e  = int'(nb[62:52]) - int'(db[62:52]) + 1023;
    if (r < dm) begin
      r = r << 1;
      e = e - 1;
    end
    q = 54'd0;
    for (int i = 0; i < 54; i++) begin
      q = {q[52:0], (r >= dm)};
      if (r >= dm) r = r - dm;
      r = r << 1;
    end
    m = {1'b0, q[53:1]} + 54'(q[0] & ((r != 55'd0) | q[1]));
    if (m[53]) begin
      m = m >> 1;
      e = e + 1;
    end
    return $bitstoreal({1'b0, 11'(e), m[51:0]});
  endfunction

  function automatic real atn_series(real t);
    real t2;
    real s;
    real term;
    int  k;
    t2 = t * t;
    s  = 0.0;
    for (k = 30; k >= 0; k--) begin
      term = div_pos(1.0, real'(2 * k + 1));
      s = s * t2 + (((k & 1) != 0) ? -term : term);
    end
    return t * s;
  endfunction

  function automatic real atn_unit(real t);
    real u;
    if (t > 0.5) begin
      u = div_pos(t - 0.5, 1.0 + 0.5 * t);
      return HALF_ATN_D + atn_series(u);
    end
    return atn_series(t);
  endfunction

  function automatic real atn_brk(real z);
    if (z > 1.0) begin
      return PIO2_R - atn_unit(div_pos(1.0, z));
    end
    return atn_unit(z);
  endfunction

  function automatic tab_t build_tab();
    tab_t tab;
    real  z;
    int   e;
    int   i;
    for (int k = 0; k < TAB_N; k++) begin
      e = k >> 4;
      z = real'(16 + (k & 15)) / 16.0;
      if (e >= 6) begin
        for (i = 0; i < e - 6; i++) z = z * 2.0;
      end else begin
        for (i = 0; i < 6 - e; i++) z = z * 0.5;
      end
      tab[k] = $realtobits(atn_brk(z));
    end
    return tab;
  endfunction

  localparam tab_t ATN_TAB = build_tab();

endpackage

`default_nettype wire

FILE: rtl/fatan_fmul.sv
// Two-stage single-precision multiplier, round to nearest even, flush to zero.
// Depends on fatan_pkg.
`default_nettype none

module fatan_fmul import fatan_pkg::*; (
  input  logic        clk,
  input  logic        ce,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  typedef struct packed {
    logic              sign;
    logic              zero;
    logic signed [9:0] exp;
    logic [47:0]       prod;
  } mul_raw_t;

  fp_t         fa, fb;
  mul_raw_t    raw, raw_next;
  logic [31:0] y_next;
  logic [23:0] mant;
  logic        rnd, stk;
  logic [24:0] mr;
  logic signed [9:0] e;

  always_comb begin
    fa = a;
    fb = b;
    raw_next.sign = fa.sign ^ fb.sign;
    raw_next.zero = (fa.exp == 8'd0) || (fb.exp == 8'd0);
    raw_next.exp  = $signed({2'b00, fa.exp}) + $signed({2'b00, fb.exp}) - 10'sd127;
    raw_next.prod = {1'b1, fa.man} * {1'b1, fb.man};
  end

  always_comb begin
    if (raw.prod[47]) begin
      mant = raw.prod[47:24];
      rnd  = raw.prod[23];
      stk  = |raw.prod[22:0];
      e    = raw.exp + 10'sd1;
    end else begin
      mant = raw.prod[46:23];
      rnd  = raw.prod[22];
      stk  = |raw.prod[21:0];
      e    = raw.exp;
    end
    mr = {1'b0, mant} + 25'(rnd & (stk | mant[0]));
    if (mr[24]) begin
      e = e + 10'sd1;
    end
    if (raw.zero || (e <= 10'sd0)) begin
      y_next = 32'd0;
    end else begin
      y_next = {raw.sign, e[7:0], (mr[24] ? mr[23:1] : mr[22:0])};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      raw <= raw_next;
      y   <= y_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fatan_fadd.sv
// Two-stage single-precision adder: align and add, then normalise and round.
// Depends on fatan_pkg.
`default_nettype none

module fatan_fadd import fatan_pkg::*; (
  input  logic        clk,
  input  logic        ce,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  typedef struct packed {
    logic        sign;
    logic        zero;
    logic [7:0]  exp;
    logic [27:0] sum;
  } add_raw_t;

  fp_t         fa, fb, big, sml;
  add_raw_t    raw, raw_next;
  logic [7:0]  d;
  logic [26:0] mb, ms, sh;
  logic        st;
  logic [4:0]  lz;
  logic [27:0] norm;
  logic [23:0] mant;
  logic        rnd, stk;
  logic [24:0] mr;
  logic signed [9:0] e;
  logic [31:0] y_next;

  always_comb begin
    fa = a;
    fb = b;
    if ({fb.exp, fb.man} > {fa.exp, fa.man}) begin
      big = fb;
      sml = fa;
    end else begin
      big = fa;
      sml = fb;
    end
    d  = big.exp - sml.exp;
    mb = {1'b1, big.man, 3'b000};
    ms = (sml.exp == 8'd0) ? 27'd0 : {1'b1, sml.man, 3'b000};
    if (d >= 8'd27) begin
      sh = 27'd0;
      st = |ms;
    end else begin
      sh = ms >> d;
      st = |(ms & ((27'd1 << d) - 27'd1));
    end
    sh[0] = sh[0] | st;
    raw_next.sign = big.sign;
    raw_next.zero = (big.exp == 8'd0);
    raw_next.exp  = big.exp;
    if (big.sign ^ sml.sign) begin
      raw_next.sum = {1'b0, mb} - {1'b0, sh};
    end else begin
      raw_next.sum = {1'b0, mb} + {1'b0, sh};
    end
  end

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 28; i++) begin
      if (raw.sum[i]) lz = 5'(27 - i);
    end
    norm = raw.sum << lz;
    mant = norm[27:4];
    rnd  = norm[3];
    stk  = |norm[2:0];
    e    = $signed({2'b00, raw.exp}) + 10'sd1 - $signed({5'b00000, lz});
    mr   = {1'b0, mant} + 25'(rnd & (stk | mant[0]));
    if (mr[24]) begin
      e = e + 10'sd1;
    end
    if (raw.zero || (raw.sum == 28'd0) || (e <= 10'sd0)) begin
      y_next = 32'd0;
    end else begin
      y_next = {raw.sign, e[7:0], (mr[24] ? mr[23:1] : mr[22:0])};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      raw <= raw_next;
      y   <= y_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fatan_fdiv.sv
// Pipelined single-precision divider: one restoring quotient bit per stage,
// then a rounding stage. Depends on fatan_pkg.
`default_nettype none

module fatan_fdiv import fatan_pkg::*; (
  input  logic        clk,
  input  logic        ce,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  localparam int unsigned QBITS = 26;

  typedef struct packed {
    logic              sign;
    logic              zero;
    logic signed [9:0] exp;
    logic [23:0]       dvs;
    logic [24:0]       rem;
    logic [25:0]       quo;
  } div_st_t;

  function automatic div_st_t div_step(div_st_t s);
    div_st_t     o;
    logic        ge;
    logic [24:0] r;
    o  = s;
    ge = s.rem >= {1'b0, s.dvs};
    r  = ge ? (s.rem - {1'b0, s.dvs}) : s.rem;
    o.rem = {r[23:0], 1'b0};
    o.quo = {s.quo[24:0], ge};
    return o;
  endfunction

  fp_t         fa, fb;
  div_st_t     init;
  div_st_t     st [QBITS];
  div_st_t     last;
  logic [23:0] mant;
  logic        rnd, stk;
  logic [24:0] mr;
  logic signed [9:0] e;
  logic [31:0] y_next;

  always_comb begin
    fa = a;
    fb = b;
    init.sign = fa.sign ^ fb.sign;
    init.zero = (fa.exp == 8'd0);
    init.exp  = $signed({2'b00, fa.exp}) - $signed({2'b00, fb.exp}) + 10'sd127;
    init.dvs  = {1'b1, fb.man};
    init.rem  = {2'b01, fa.man};
    init.quo  = 26'd0;
  end

  always_comb begin
    last = st[QBITS-1];
    if (last.quo[25]) begin
      mant = last.quo[25:2];
      rnd  = last.quo[1];
      stk  = last.quo[0] | (last.rem != 25'd0);
      e    = last.exp;
    end else begin
      mant = last.quo[24:1];
      rnd  = last.quo[0];
      stk  = (last.rem != 25'd0);
      e    = last.exp - 10'sd1;
    end
    mr = {1'b0, mant} + 25'(rnd & (stk | mant[0]));
    if (mr[24]) begin
      e = e + 10'sd1;
    end
    if (last.zero || (e <= 10'sd0)) begin
      y_next = 32'd0;
    end else begin
      y_next = {last.sign, e[7:0], (mr[24] ? mr[23:1] : mr[22:0])};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      st[0] <= div_step(init);
      for (int i = 1; i < QBITS; i++) begin
        st[i] <= div_step(st[i-1]);
      end
      y <= y_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fatan_dadd.sv
// Three-stage adder of a double-precision table value and a single-precision
// term: add, round to double, round again to single. Depends on fatan_pkg.
`default_nettype none

module fatan_dadd import fatan_pkg::*; (
  input  logic        clk,
  input  logic        ce,
  input  logic [63:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  typedef struct packed {
    logic        sign;
    logic        zero;
    logic [10:0] exp;
    logic [56:0] sum;
  } dadd_raw_t;

  typedef struct packed {
    logic               sign;
    logic               zero;
    logic signed [12:0] exp;
    logic [52:0]        man;
  } dbl_t;

  fp_t         fb;
  logic        sa, sb, za, zb, sbig, ssml, zbig;
  logic [10:0] ea, eb, ebig, esml, d;
  logic [51:0] ma, mbb, mbig, msml;
  logic [55:0] xb, xs, sh;
  logic        st;
  dadd_raw_t   raw, raw_next;
  logic [5:0]  lz;
  logic [56:0] norm;
  logic [52:0] m53;
  logic        rnd, stk, rnd2, stk2;
  logic [53:0] mr;
  logic signed [12:0] e, es;
  dbl_t        dv, dv_next;
  logic [24:0] mr2;
  logic [31:0] y_next;

  always_comb begin
    fb  = b;
    sa  = a[63];
    ea  = a[62:52];
    ma  = a[51:0];
    za  = (ea == 11'd0);
    sb  = fb.sign;
    za  = za;
    zb  = (fb.exp == 8'd0);
    eb  = {3'b000, fb.exp} + 11'd896;
    mbb = {fb.man, 29'd0};
    if (zb || (!za && ({ea, ma} >= {eb, mbb}))) begin
      sbig = sa; ebig = ea; mbig = ma; zbig = za;
      ssml = sb; esml = eb; msml = mbb;
      xs   = zb ? 56'd0 : {1'b1, mbb, 3'b000};
    end else begin
      sbig = sb; ebig = eb; mbig = mbb; zbig = zb;
      ssml = sa; esml = ea; msml = ma;
      xs   = za ? 56'd0 : {1'b1, ma, 3'b000};
    end
    xb = {1'b1, mbig, 3'b000};
    d  = ebig - esml;
    if (d >= 11'd56) begin
      sh = 56'd0;
      st = |xs;
    end else begin
      sh = xs >> d;
      st = |(xs & ((56'd1 << d) - 56'd1));
    end
    sh[0] = sh[0] | st;
    raw_next.sign = sbig;
    raw_next.zero = zbig;
    raw_next.exp  = ebig;
    if (sbig ^ ssml) begin
      raw_next.sum = {1'b0, xb} - {1'b0, sh};
    end else begin
      raw_next.sum = {1'b0, xb} + {1'b0, sh};
    end
    if (msml == 52'd0) begin
      raw_next.sign = raw_next.sign;
    end
  end

  // Normalise and round to double.
  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 57; i++) begin
      if (raw.sum[i]) lz = 6'(56 - i);
    end
    norm = raw.sum << lz;
    m53  = norm[56:4];
    rnd  = norm[3];
    stk  = |norm[2:0];
    e    = $signed({2'b00, raw.exp}) + 13'sd1 - $signed({7'd0, lz});
    mr   = {1'b0, m53} + 54'(rnd & (stk | m53[0]));
    if (mr[53]) begin
      e = e + 13'sd1;
    end
    dv_next.sign = raw.sign;
    dv_next.zero = raw.zero || (raw.sum == 57'd0);
    dv_next.exp  = e;
    dv_next.man  = mr[53] ? mr[53:1] : mr[52:0];
  end

  // Round the double to single.
  always_comb begin
    rnd2 = dv.man[28];
    stk2 = |dv.man[27:0];
    mr2  = {1'b0, dv.man[52:29]} + 25'(rnd2 & (stk2 | dv.man[29]));
    es   = dv.exp - 13'sd896;
    if (mr2[24]) begin
      es = es + 13'sd1;
    end
    if (dv.zero || (es <= 13'sd0)) begin
      y_next = 32'd0;
    end else begin
      y_next = {dv.sign, es[7:0], (mr2[24] ? mr2[23:1] : mr2[22:0])};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      raw <= raw_next;
      dv  <= dv_next;
      y   <= y_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/float32_arctangent.sv
// Single-precision arctangent, fully pipelined.
// Depends on fatan_pkg, fatan_fmul, fatan_fadd, fatan_fdiv and fatan_dadd.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready/s_tdata, one IEEE single bit
//   pattern each; results leave on m_tvalid/m_tready/m_tdata in the same
//   order, one result word per input word.
//   Throughput: one word per cycle, sustained, whenever the receiver keeps
//   m_tready high. Every stage is a register slice, and the divider makes one
//   quotient bit per stage, so nothing is iterated in place.
//   Stages: the input stage loaded at the accepting edge, 42 further
//   datapath stages, the longest part being the 27-stage divider, then the
//   output register, which drives m_tvalid.
//   Reset (rst, synchronous, active high) drops every word in flight and
//   empties the output register and the skid slot; no table clearing is
//   needed, the breakpoint table is constant.
//   Stall: when m_tready is low the output word holds, the next word to
//   leave the pipeline drops into a one-word skid slot, and only then does
//   s_tready fall and the whole pipeline hold. Nothing is lost or repeated.
`default_nettype none

module float32_arctangent import fatan_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] x_bits
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [31:0] y_bits
);

  localparam int unsigned DEPTH   = 43;
  localparam int unsigned ST_DEN  = 4;   // denominator ready
  localparam int unsigned ST_F    = 31;  // reduced argument ready
  localparam int unsigned ST_POLY = 39;  // polynomial ready
  localparam int unsigned FD_N    = 6;

  typedef struct packed {
    logic        v;
    logic [31:0] x;
    logic        nan;
    logic        tiny;
    logic        big;
    path_t       path;
    logic [7:0]  k;
  } side_t;

  side_t       sd [DEPTH];
  side_t       dec;
  logic        ce;
  logic [30:0] mag, zb, kdiff;
  logic [31:0] prod, num, den, quo, f_sel, p_v, q_v, r_v, poly, res;
  logic [31:0] nd [2];
  logic [31:0] fd [FD_N];
  logic [31:0] div_a, div_b;
  logic [63:0] conup;
  side_t       tail;
  logic [31:0] y_fin;
  logic        ov, skid_v, out_free;
  logic [31:0] od, skid_d;

  assign ce       = !skid_v;
  assign s_tready = ce;

  // Classify the argument and find its breakpoint.
  always_comb begin
    mag      = s_tdata[30:0];
    zb       = (mag + BRK_RND) & BRK_KEEP;
    kdiff    = zb - SIXTY4TH;
    dec.v    = s_tvalid;
    dec.x    = s_tdata;
    dec.nan  = mag > INF_MAG;
    dec.tiny = mag < TINY_MAG;
    dec.big  = mag > BIG_MAG;
    dec.k    = kdiff[26:19];
    if (mag > SIXTYFOUR) begin
      dec.path = PATH_RECIP;
    end else if (mag >= SIXTY4TH) begin
      dec.path = PATH_MID;
    end else begin
      dec.path = PATH_SMALL;
    end
  end

  // Hold side data alongside the arithmetic; reset drops valid words only.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) sd[i].v <= 1'b0;
    end else if (ce) begin
      sd[0] <= dec;
      for (int i = 1; i < DEPTH; i++) sd[i] <= sd[i-1];
    end
  end

  // Breakpoint value rebuilt from the stage-0 magnitude.
  logic [31:0] x0, z0, zneg;
  always_comb begin
    x0   = {1'b0, sd[0].x[30:0]};
    z0   = {1'b0, (x0[30:0] + BRK_RND) & BRK_KEEP};
    zneg = {1'b1, z0[30:0]};
  end

  fatan_fmul u_xz  (.clk(clk), .ce(ce), .a(x0), .b(z0), .y(prod));
  fatan_fadd u_num (.clk(clk), .ce(ce), .a(x0), .b(zneg), .y(num));
  fatan_fadd u_den (.clk(clk), .ce(ce), .a(ONE_BITS), .b(prod), .y(den));

  always_ff @(posedge clk) begin
    if (ce) begin
      nd[0] <= num;
      nd[1] <= nd[0];
    end
  end

  // Reciprocal path divides one by the magnitude; the sign is put on after.
  always_comb begin
    if (sd[ST_DEN].path == PATH_RECIP) begin
      div_a = ONE_BITS;
      div_b = {1'b0, sd[ST_DEN].x[30:0]};
    end else begin
      div_a = nd[1];
      div_b = den;
    end
  end

  fatan_fdiv u_div (.clk(clk), .ce(ce), .a(div_a), .b(div_b), .y(quo));

  always_comb begin
    case (sd[ST_F].path)
      PATH_SMALL: f_sel = {1'b0, sd[ST_F].x[30:0]};
      PATH_RECIP: f_sel = {1'b1, quo[30:0]};
      default:    f_sel = quo;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      fd[0] <= f_sel;
      for (int i = 1; i < FD_N; i++) fd[i] <= fd[i-1];
    end
  end

  // Odd cubic p1*f^3 + f, each step rounded to single.
  fatan_fmul u_p    (.clk(clk), .ce(ce), .a(P1_BITS), .b(f_sel), .y(p_v));
  fatan_fmul u_q    (.clk(clk), .ce(ce), .a(p_v), .b(fd[1]), .y(q_v));
  fatan_fmul u_r    (.clk(clk), .ce(ce), .a(q_v), .b(fd[3]), .y(r_v));
  fatan_fadd u_poly (.clk(clk), .ce(ce), .a(r_v), .b(fd[5]), .y(poly));

  always_comb begin
    case (sd[ST_POLY].path)
      PATH_RECIP: conup = PIO2_D;
      PATH_MID:   conup = ATN_TAB[sd[ST_POLY].k];
      default:    conup = 64'd0;
    endcase
  end

  fatan_dadd u_sum (.clk(clk), .ce(ce), .a(conup), .b(poly), .y(res));

  // Special cases override the arithmetic result.
  always_comb begin
    tail = sd[DEPTH-1];
    if (tail.nan) begin
      y_fin = {1'b0, tail.x[30:0]} | QUIET_BIT;
    end else if (tail.tiny) begin
      y_fin = tail.x;
    end else if (tail.big) begin
      y_fin = {tail.x[31], PIO2_F[30:0]};
    end else begin
      y_fin = res ^ {tail.x[31], 31'd0};
    end
  end

  // Output register with a one-word skid slot behind it.
  assign out_free = !ov || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov     <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (out_free) begin
        od     <= skid_d;
        ov     <= 1'b1;
        skid_v <= 1'b0;
      end
    end else if (tail.v) begin
      if (out_free) begin
        od <= y_fin;
        ov <= 1'b1;
      end else begin
        skid_d <= y_fin;
        skid_v <= 1'b1;
      end
    end else if (out_free) begin
      ov <= 1'b0;
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = od;

endmodule

`default_nettype wire

FILE: dv/float32_arctangent_checker.sv
// Scoreboard for float32_arctangent: predicts each result from the input word
// and compares it with the output word. Depends on fatan_pkg for constants.
`timescale 1ns / 100ps

module float32_arctangent_checker import fatan_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] x_bits
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // [31:0] y_bits
  output int          errors,
  output int          pending,
  output int          checked
);

  logic [31:0] atan_queue[$];

  // Single bit pattern to real, subnormals included.
  function automatic real sp_to_real(logic [31:0] b);
    logic [10:0] de;
    real         v;
    if (b[30:23] == 8'd0) begin
      v = real'(b[22:0]) / (2.0 ** 149);
      return b[31] ? -v : v;
    end
    de = {3'b000, b[30:23]} + 11'd896;
    return $bitstoreal({b[31], de, b[22:0], 29'd0});
  endfunction

  // Round a double to single, nearest-even, with gradual underflow.
  function automatic logic [31:0] real_to_sp(real v);
    logic [63:0] d;
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    int          ex;
    int          sh;
    d = $realtobits(v);
    if (d[62:52] == 11'd0) return {d[63], 31'd0};
    m  = {11'd0, 1'b1, d[51:0]};
    ex = int'(d[62:52]) - 1023;
    if (ex > 127) return {d[63], 8'hFF, 23'd0};
    sh = (ex >= -126) ? 29 : (-ex - 97);
    if (sh > 60) return {d[63], 31'd0};
    q    = m >> sh;
    rem  = m & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    if (ex >= -126) begin
      if (q == (64'd1 << 24)) begin
        q  = 64'd1 << 23;
        ex = ex + 1;
      end
      if (ex > 127) return {d[63], 8'hFF, 23'd0};
      return {d[63], 8'(ex + 127), q[22:0]};
    end
    // a carry into bit 23 lands on the smallest normal by itself
    return {d[63], q[30:0]};
  endfunction

  // Double evaluation of one single operation is exact enough to round once.
  function automatic logic [31:0] sp_mul(logic [31:0] a, logic [31:0] b);
    return real_to_sp(sp_to_real(a) * sp_to_real(b));
  endfunction

  function automatic logic [31:0] sp_add(logic [31:0] a, logic [31:0] b);
    return real_to_sp(sp_to_real(a) + sp_to_real(b));
  endfunction

  function automatic logic [31:0] sp_sub(logic [31:0] a, logic [31:0] b);
    return real_to_sp(sp_to_real(a) - sp_to_real(b));
  endfunction

  function automatic logic [31:0] sp_div(logic [31:0] a, logic [31:0] b);
    return real_to_sp(sp_to_real(a) / sp_to_real(b));
  endfunction

  // Maclaurin series for |t| <= 0.5, Horner form, 31 terms.
  function automatic real arc_series(real t);
    real t2;
    real s;
    real term;
    t2 = t * t;
    s  = 0.0;
    for (int k = 30; k >= 0; k--) begin
      term = 1.0 / real'(2 * k + 1);
      s = s * t2 + (((k % 2) == 1) ? -term : term);
    end
    return t * s;
  endfunction

  function automatic real arc_unit(real t);
    if (t > 0.5) return 0.46364760900080611621 + arc_series((t - 0.5) / (1.0 + 0.5 * t));
    return arc_series(t);
  endfunction

  function automatic real breakpoint_atan(real z);
    if (z > 1.0) return $bitstoreal(PIO2_D) - arc_unit(1.0 / z);
    return arc_unit(z);
  endfunction

  function automatic logic [31:0] predict_atan(logic [31:0] x);
    logic [30:0] mag;
    logic [30:0] brk;
    logic [31:0] f;
    logic [31:0] num;
    logic [31:0] den;
    logic [31:0] cube;
    logic [31:0] poly;
    real         base;
    mag = x[30:0];
    if (mag > INF_MAG) return {1'b0, mag} | QUIET_BIT;
    if (mag < TINY_MAG) return x;
    if (mag > BIG_MAG) return {x[31], PIO2_F[30:0]};
    f = {1'b0, mag};
    if (mag > SIXTYFOUR) begin
      f    = sp_div(32'hBF800000, {1'b0, mag});
      base = $bitstoreal(PIO2_D);
    end else if (mag >= SIXTY4TH) begin
      brk  = (mag + BRK_RND) & BRK_KEEP;
      num  = sp_sub({1'b0, mag}, {1'b0, brk});
      den  = sp_add(ONE_BITS, sp_mul({1'b0, mag}, {1'b0, brk}));
      f    = sp_div(num, den);
      base = breakpoint_atan(sp_to_real({1'b0, brk}));
    end else begin
      base = 0.0;
    end
    cube = sp_mul(sp_mul(sp_mul(P1_BITS, f), f), f);
    poly = sp_add(cube, f);
    return real_to_sp(base + sp_to_real(poly)) ^ {x[31], 31'd0};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      atan_queue.delete();
      errors  <= 0;
      checked <= 0;
      pending <= 0;
    end else begin
      // predict on the way in, compare on the way out
      if (s_tvalid && s_tready) atan_queue.push_back(predict_atan(s_tdata));
      if (m_tvalid && m_tready) begin
        if (atan_queue.size() == 0) begin
          if (errors < 10) $display("ERROR: unexpected result word %h", m_tdata);
          errors <= errors + 1;
        end else begin
          if (m_tdata !== atan_queue[0]) begin
            if (errors < 10)
              $display("ERROR: y_bits expected %h got %h", atan_queue[0], m_tdata);
            errors <= errors + 1;
          end
          void'(atan_queue.pop_front());
          checked <= checked + 1;
        end
      end
      pending <= atan_queue.size();
    end
  end

endmodule

FILE: dv/float32_arctangent_tb.sv
// Testbench top for float32_arctangent: clock, reset, stimulus, output
// stalls and verdict. Depends on float32_arctangent and its checker.
`timescale 1ns / 100ps

module float32_arctangent_tb;

  localparam int RANDOM_WORDS = 1600;
  localparam int CALM_WORDS   = 200;   // tail of the run with no idling
  localparam int HOLD_CYCLES  = 150;   // long receiver hold-off
  localparam int STALL_LIMIT  = 1000;  // watchdog: cycles with no handshake

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = 32'd0;   // [31:0] x_bits
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // [31:0] y_bits

  int errors;
  int pending;
  int checked;
  int words_sent = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  // Directed arguments: zeros, subnormals, each range boundary, NaNs, infinities.
  logic [31:0] corner_args[] = '{
    32'h00000000, 32'h80000000, 32'h00000001, 32'h807FFFFF,
    32'h317FFFFF, 32'h31800000, 32'hB1800000, 32'h3C7FFFFF,
    32'h3C800000, 32'hBC800000, 32'h3F800000, 32'hBF800000,
    32'h3FFC0000, 32'h3FFBFFFF, 32'h42800000, 32'h42800001,
    32'hC2800001, 32'h5B000000, 32'h5B000001, 32'h7F7FFFFF,
    32'h7F800000, 32'hFF800000, 32'h7F800001, 32'hFFC00000,
    32'h7FFFFFFF
  };

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  float32_arctangent i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  float32_arctangent_checker i_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .pending  (pending),
    .checked  (checked)
  );

  // Offer one word and hold it until the block takes it, then maybe idle.
  task automatic send_word(input logic [31:0] x);
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Argument mix: mostly main path, then boundaries, breakpoints, random words.
  function automatic logic [31:0] pick_arg();
    int          sel;
    logic [31:0] x;
    sel = $urandom_range(0, 99);
    x   = $urandom;
    if (sel < 60) begin
      // exponent from 2^-29 to 2^56: magnitudes from 2^-29 to just under 2^57
      x[30:23] = 8'($urandom_range(98, 183));
    end else if (sel < 75) begin
      // close to a range boundary
      case ($urandom_range(0, 3))
        0: x[30:0] = 31'h31800000 + 31'($urandom_range(0, 8)) - 31'd4;
        1: x[30:0] = 31'h3C800000 + 31'($urandom_range(0, 8)) - 31'd4;
        2: x[30:0] = 31'h42800000 + 31'($urandom_range(0, 8)) - 31'd4;
        default: x[30:0] = 31'h5B000000 + 31'($urandom_range(0, 8)) - 31'd4;
      endcase
    end else if (sel < 82) begin
      // breakpoint rounding: low mantissa bits right around the half step
      x[30:23] = 8'($urandom_range(121, 133));
      x[18:0]  = 19'h40000 + 19'($urandom_range(0, 4)) - 19'd2;
    end
    return x;
  endfunction

  // Receiver: random short stalls, and one long hold-off on request.
  always begin
    @(posedge clk);
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      m_tready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_done = 1'b1;
      m_tready <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
      m_tready <= 1'b1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (corner_args[i]) send_word(corner_args[i]);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // halfway through, freeze the receiver so the pipeline backs up
      if (n == RANDOM_WORDS / 2) hold_req = 1'b1;
      if (n == RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
      send_word(pick_arg());
    end
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d argument words (boundaries, NaNs, infinities, subnormals among them)",
             words_sent);
    $display("Checked %0d arctangent results, %0d mismatches", checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: float32_arctangent.f
rtl/fatan_pkg.sv
rtl/fatan_fmul.sv
rtl/fatan_fadd.sv
rtl/fatan_fdiv.sv
rtl/fatan_dadd.sv
rtl/float32_arctangent.sv
dv/float32_arctangent_checker.sv
dv/float32_arctangent_tb.sv
